// ===== sv/pve_pkg.sv =====
`default_nettype none
package pve_pkg;

  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int MAX_LENGTH_DEF    = 65536;

  localparam int SYM_W      = 8;
  localparam int POS_W      = 16;
  localparam int MASK_W     = 64;
  localparam int MASK_REGS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_MASK_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_MASK_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_MASK_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_MASK_3 = 3'd3;

  // Control from the front stage to the history store.
  typedef struct packed {
    logic fire;
    logic clear;
    logic is_param;
  } hist_req_t;

endpackage
`default_nettype wire

// ===== sv/pve_history.sv =====
`default_nettype none
module pve_history import pve_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hist_req_t        req,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [POS_W-1:0] wr_pos,
  output logic [POS_W-1:0]      prev_pos_r,
  output logic                  seen_r
);

  logic [POS_W-1:0]         mem_r [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_r;
  logic [ALPHABET_SIZE-1:0] valid_nxt;

  always_comb begin
    valid_nxt = req.clear ? '0 : valid_r;
    if (req.is_param) begin
      valid_nxt[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.fire) begin
      valid_r <= valid_nxt;
    end
  end

  // The read returns the entry as it was before this beat's own write.
  always_ff @(posedge clk) begin
    if (req.fire) begin
      prev_pos_r <= mem_r[addr];
      seen_r     <= req.clear ? 1'b0 : valid_r[addr];
      if (req.is_param) begin
        mem_r[addr] <= wr_pos;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/parameterized_prev_encoder_unit.sv =====
// An accepted input beat passes the second-stage and output registers before its result is on the output.
// Throughput: one symbol per cycle while the output is not stalled, set by the
// single read-modify-write of the position memory per symbol, with the running maximum updated one stage later.
// Reset (synchronous, active low) clears the valid bits, position, maximum,
// overflow flag, masks and pipeline valids at once; no clearing pass is needed.
`default_nettype none
module parameterized_prev_encoder_unit import pve_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int MAX_LENGTH    = MAX_LENGTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] symbol
  input  wire logic                  in_tuser,   // [0] start_req
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [15:0] code_value, [31:16] max_distance,
                                                 // [32] length_overflow, [39:33] zero
  output logic                       out_tuser,  // [0] is_distance
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [MASK_W-1:0]     cfg_data
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int LAST_POS_I = (MAX_LENGTH - 1 > 65535) ? 65535 : MAX_LENGTH - 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LAST_POS_I);

  logic [MASK_REGS-1:0][MASK_W-1:0] mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PARAM_MASK_0: mask_r[0] <= cfg_data;
        CFG_PARAM_MASK_1: mask_r[1] <= cfg_data;
        CFG_PARAM_MASK_2: mask_r[2] <= cfg_data;
        CFG_PARAM_MASK_3: mask_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic out_valid_r;
  logic s1_valid_r;
  logic out_en;
  logic in_fire;

  assign out_en    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_en;
  assign in_fire   = in_tvalid && in_tready;

  // Front stage: position and parameter lookup.
  logic [SYM_W-1:0] sym;
  logic             start;
  logic             in_range;
  logic             is_param;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             last_used_r, last_used_nxt;
  logic             ovf_r, ovf_nxt;
  logic [POS_W-1:0] cur;

  assign sym      = in_tdata[SYM_W-1:0];
  assign start    = in_tuser;
  assign in_range = {1'b0, sym} < 9'(ALPHABET_SIZE);
  assign is_param = in_range && mask_r[sym[7:6]][sym[5:0]];

  always_comb begin
    pos_nxt       = start ? '0 : pos_r;
    last_used_nxt = start ? 1'b0 : last_used_r;
    ovf_nxt       = start ? 1'b0 : ovf_r;
    if (last_used_nxt) begin
      cur     = LAST_POS;
      ovf_nxt = 1'b1;
    end else begin
      cur = pos_nxt;
      if (pos_nxt >= LAST_POS) begin
        cur           = LAST_POS;
        last_used_nxt = 1'b1;
      end else begin
        pos_nxt = pos_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      last_used_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else if (in_fire) begin
      pos_r       <= pos_nxt;
      last_used_r <= last_used_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  hist_req_t        hreq;
  logic [POS_W-1:0] prev_pos_r;
  logic             seen_r;

  assign hreq.fire     = in_fire;
  assign hreq.clear    = start;
  assign hreq.is_param = is_param;

  pve_history #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (hreq),
    .addr      (sym[AW-1:0]),
    .wr_pos    (cur),
    .prev_pos_r(prev_pos_r),
    .seen_r    (seen_r)
  );

  // Second stage: distance and running maximum.
  logic [SYM_W-1:0] s1_sym_r;
  logic [POS_W-1:0] s1_cur_r;
  logic             s1_param_r;
  logic             s1_start_r;
  logic             s1_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sym_r   <= sym;
      s1_cur_r   <= cur;
      s1_param_r <= is_param;
      s1_start_r <= start;
      s1_ovf_r   <= ovf_nxt;
    end
  end

  logic [POS_W-1:0] run_max_r, run_max_nxt;
  logic [POS_W-1:0] max_base;
  logic [POS_W-1:0] code;

  always_comb begin
    max_base = s1_start_r ? '0 : run_max_r;
    if (!s1_param_r) begin
      code = {{(POS_W-SYM_W){1'b0}}, s1_sym_r};
    end else if (seen_r && (s1_cur_r >= prev_pos_r)) begin
      code = s1_cur_r - prev_pos_r;
    end else begin
      code = '0;
    end
    run_max_nxt = max_base;
    if (s1_param_r && (code > max_base)) begin
      run_max_nxt = code;
    end
  end

  logic             s1_move;
  logic [POS_W-1:0] out_code_r;
  logic [POS_W-1:0] out_max_r;
  logic             out_isd_r;
  logic             out_ovf_r;

  assign s1_move = s1_valid_r && out_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        run_max_r <= run_max_nxt;
      end
      if (out_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_code_r <= code;
      out_max_r  <= run_max_nxt;
      out_isd_r  <= s1_param_r;
      out_ovf_r  <= s1_ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_ovf_r, out_max_r, out_code_r};
  assign out_tuser  = out_isd_r;

  // A constant symbol is always a byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_isd_r |-> out_code_r[POS_W-1:SYM_W] == '0)
    else $error("constant code wider than a symbol");

  // The reported maximum covers every distance emitted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_isd_r |-> out_code_r <= out_max_r)
    else $error("distance exceeds running maximum");

  // Overflow is only raised once the position has saturated.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_ovf_r |-> s1_cur_r == LAST_POS)
    else $error("overflow without saturated position");

endmodule
`default_nettype wire
